>>> src/bgrf_pkg.sv
// shared types and constants of the burst group receive feedback block
package bgrf_pkg;

  localparam int CNT_W = 13;
  localparam int TOT_W = 27;
  localparam int CAP_W = 21;
  localparam int ICNT_W = 5;

  localparam logic [1:0] KIND_ACK = 2'd0;
  localparam logic [1:0] KIND_SUM = 2'd1;
  localparam logic [1:0] KIND_INTV = 2'd2;

  typedef struct packed {
    logic take;
    logic store;
    logic open;
    logic close;
    logic calc_start;
    logic calc_step;
    logic load_ack;
    logic load_sum;
    logic load_intv;
    logic last;
  } dp_cmd_t;

  typedef struct packed {
    logic cur_zero;
    logic gid_match;
    logic count_zero;
    logic out_free;
    logic calc_done;
    logic cnt_zero;
    logic intv_last;
  } dp_stat_t;

endpackage

>>> src/bgrf_ctrl.sv
// controller state machine sequencing acks, summaries and interval results
module bgrf_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               group_end,
  input  bgrf_pkg::dp_stat_t stat,
  output bgrf_pkg::dp_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CINIT = 3'd1;
  localparam logic [2:0] S_CALC = 3'd2;
  localparam logic [2:0] S_SUM = 3'd3;
  localparam logic [2:0] S_INTV = 3'd4;
  localparam logic [2:0] S_ACK = 3'd5;

  logic [2:0] state, state_next;
  logic pre, pre_next;
  logic openf, openf_next;
  logic end_l, end_l_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    pre_next = pre;
    openf_next = openf;
    end_l_next = end_l;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take = 1'b1;
          end_l_next = group_end;
          if (!stat.cur_zero && !stat.gid_match && !stat.count_zero) begin
            // old group feedback goes out before the ack
            pre_next = 1'b1;
            openf_next = 1'b0;
            state_next = S_CINIT;
          end else begin
            pre_next = 1'b0;
            openf_next = stat.cur_zero | !stat.gid_match;
            state_next = S_ACK;
          end
        end
      end
      S_ACK: begin
        if (stat.out_free) begin
          cmd.load_ack = 1'b1;
          cmd.store = 1'b1;
          cmd.open = openf;
          cmd.last = !end_l;
          pre_next = 1'b0;
          state_next = end_l ? S_CINIT : S_IDLE;
        end
      end
      S_CINIT: begin
        cmd.calc_start = 1'b1;
        state_next = S_CALC;
      end
      S_CALC: begin
        if (stat.calc_done) begin
          state_next = S_SUM;
        end else begin
          cmd.calc_step = 1'b1;
        end
      end
      S_SUM: begin
        if (stat.out_free) begin
          cmd.load_sum = 1'b1;
          cmd.last = !pre && stat.cnt_zero;
          if (!stat.cnt_zero) begin
            state_next = S_INTV;
          end else if (pre) begin
            openf_next = 1'b1;
            state_next = S_ACK;
          end else begin
            cmd.close = 1'b1;
            state_next = S_IDLE;
          end
        end
      end
      S_INTV: begin
        if (stat.out_free) begin
          cmd.load_intv = 1'b1;
          cmd.last = !pre && stat.intv_last;
          if (stat.intv_last) begin
            if (pre) begin
              openf_next = 1'b1;
              state_next = S_ACK;
            end else begin
              cmd.close = 1'b1;
              state_next = S_IDLE;
            end
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pre <= 1'b0;
      openf <= 1'b0;
      end_l <= 1'b0;
    end else begin
      state <= state_next;
      pre <= pre_next;
      openf <= openf_next;
      end_l <= end_l_next;
    end
  end

endmodule

>>> src/bgrf_dp.sv
// datapath: group statistics, interval counting and the output register
module bgrf_dp #(
  parameter int MAX_PACKETS = 2048,
  parameter int MAX_INTERVALS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  bgrf_pkg::dp_cmd_t  cmd,
  output bgrf_pkg::dp_stat_t stat,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_data,
  output logic [15:0]        interval_size,
  input  logic [31:0]        grp_id,
  input  logic [15:0]        pkt_seq,
  input  logic [15:0]        pkt_len,
  input  logic [63:0]        receive_time_us,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         kind,
  output logic [15:0]        ack_seq,
  output logic [63:0]        first_time_us,
  output logic [63:0]        last_time_us,
  output logic [31:0]        fb_group_id,
  output logic [11:0]        packet_total,
  output logic [15:0]        low_pkt_len,
  output logic [20:0]        grp_bytes,
  output logic [4:0]         intv_cnt,
  output logic [4:0]         interval_index,
  output logic [15:0]        interval_bytes,
  output logic               last
);

  localparam logic [bgrf_pkg::CNT_W-1:0] MAX_CNT = bgrf_pkg::CNT_W'(MAX_PACKETS);
  localparam logic [bgrf_pkg::CAP_W-1:0] NINT = bgrf_pkg::CAP_W'(MAX_INTERVALS);

  // latched transaction
  logic [31:0] gid_l;
  logic [15:0] seq_l;
  logic [15:0] psize_l;
  logic [63:0] time_l;

  // group state
  logic [31:0] current_group;
  logic [bgrf_pkg::CNT_W-1:0] stored_count;
  logic [bgrf_pkg::TOT_W-1:0] total_bytes;
  logic [15:0] low_seq, low_seq_size, high_seq;
  logic [63:0] low_seq_time, high_seq_time;

  // interval counting
  logic [bgrf_pkg::CAP_W-1:0] tot, rem, rem2;
  logic [bgrf_pkg::ICNT_W-1:0] cnt, k;

  logic [bgrf_pkg::CNT_W-1:0] eff_count;
  logic [bgrf_pkg::TOT_W-1:0] eff_total;
  logic [bgrf_pkg::CAP_W-1:0] cap, tot_calc, size_w;
  logic [15:0] intv_val;

  assign size_w = bgrf_pkg::CAP_W'(interval_size);
  assign cap = NINT * size_w;
  assign tot_calc = (total_bytes < bgrf_pkg::TOT_W'(cap)) ?
                    bgrf_pkg::CAP_W'(total_bytes) : cap;
  assign eff_count = cmd.open ? '0 : stored_count;
  assign eff_total = cmd.open ? '0 : total_bytes;
  assign intv_val = (rem2 > size_w) ? interval_size : rem2[15:0];

  assign stat.cur_zero = (current_group == 32'd0);
  assign stat.gid_match = (current_group == grp_id);
  assign stat.count_zero = (stored_count == '0);
  assign stat.out_free = !out_valid || !out_stall;
  assign stat.calc_done = (rem == '0) || (interval_size == 16'd0);
  assign stat.cnt_zero = (cnt == '0);
  assign stat.intv_last = (k == cnt - 5'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      interval_size <= 16'd4096;
    end else if (cfg_we) begin
      interval_size <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      gid_l <= grp_id;
      seq_l <= pkt_seq;
      psize_l <= pkt_len;
      time_l <= receive_time_us;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_group <= '0;
      stored_count <= '0;
      total_bytes <= '0;
      low_seq <= '0;
      low_seq_time <= '0;
      low_seq_size <= '0;
      high_seq <= '0;
      high_seq_time <= '0;
    end else if (cmd.close) begin
      current_group <= '0;
      stored_count <= '0;
      total_bytes <= '0;
      low_seq <= '0;
      low_seq_time <= '0;
      low_seq_size <= '0;
      high_seq <= '0;
      high_seq_time <= '0;
    end else if (cmd.store) begin
      if (cmd.open) begin
        current_group <= gid_l;
        stored_count <= '0;
        total_bytes <= '0;
      end
      if (eff_count < MAX_CNT) begin
        if (eff_count == '0) begin
          low_seq <= seq_l;
          low_seq_time <= time_l;
          low_seq_size <= psize_l;
          high_seq <= seq_l;
          high_seq_time <= time_l;
        end else begin
          if (seq_l < low_seq) begin
            low_seq <= seq_l;
            low_seq_time <= time_l;
            low_seq_size <= psize_l;
          end
          if (seq_l > high_seq) begin
            high_seq <= seq_l;
            high_seq_time <= time_l;
          end
        end
        stored_count <= eff_count + 1'b1;
        total_bytes <= eff_total + bgrf_pkg::TOT_W'(psize_l);
      end
    end
  end

  // count intervals by repeated subtraction, one interval per cycle
  always_ff @(posedge clk) begin
    if (cmd.calc_start) begin
      tot <= tot_calc;
      rem <= tot_calc;
      cnt <= '0;
    end else if (cmd.calc_step) begin
      rem <= (rem > size_w) ? rem - size_w : '0;
      cnt <= cnt + 1'b1;
    end
    if (cmd.load_sum) begin
      rem2 <= tot;
      k <= '0;
    end else if (cmd.load_intv) begin
      rem2 <= rem2 - bgrf_pkg::CAP_W'(intv_val);
      k <= k + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_ack || cmd.load_sum || cmd.load_intv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_ack || cmd.load_sum || cmd.load_intv) begin
      kind <= bgrf_pkg::KIND_ACK;
      ack_seq <= '0;
      first_time_us <= '0;
      last_time_us <= '0;
      fb_group_id <= '0;
      packet_total <= '0;
      low_pkt_len <= '0;
      grp_bytes <= '0;
      intv_cnt <= '0;
      interval_index <= '0;
      interval_bytes <= '0;
      last <= cmd.last;
      if (cmd.load_ack) begin
        ack_seq <= seq_l;
        first_time_us <= time_l;
      end else if (cmd.load_sum) begin
        kind <= bgrf_pkg::KIND_SUM;
        first_time_us <= low_seq_time;
        last_time_us <= high_seq_time;
        fb_group_id <= current_group;
        packet_total <= stored_count[11:0];
        low_pkt_len <= low_seq_size;
        grp_bytes <= tot;
        intv_cnt <= cnt;
      end else begin
        kind <= bgrf_pkg::KIND_INTV;
        fb_group_id <= current_group;
        interval_index <= k;
        interval_bytes <= intv_val;
      end
    end
  end

endmodule

>>> src/burst_group_receive_feedback.sv
// top level of the burst group receive feedback block
// Each packet transaction yields an ack; a change of group or a group end also
// yields a summary and one result per byte interval. A plain packet is accepted,
// then its ack is loaded. For feedback, the interval count n is found by
// repeated subtraction of the interval size, one step per cycle, then the summary
// and n interval results leave one per cycle. Output stalls lengthen every result load.
// Config writes must only be made while the block is idle.
module burst_group_receive_feedback #(
  parameter int MAX_PACKETS = 2048,
  parameter int MAX_INTERVALS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] grp_id,
  input  logic [15:0] pkt_seq,
  input  logic [15:0] pkt_len,
  input  logic        group_end,
  input  logic [63:0] receive_time_us,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [15:0] ack_seq,
  output logic [63:0] first_time_us,
  output logic [63:0] last_time_us,
  output logic [31:0] fb_group_id,
  output logic [11:0] packet_total,
  output logic [15:0] low_pkt_len,
  output logic [20:0] grp_bytes,
  output logic [4:0]  intv_cnt,
  output logic [4:0]  interval_index,
  output logic [15:0] interval_bytes,
  output logic        last
);

  bgrf_pkg::dp_cmd_t cmd;
  bgrf_pkg::dp_stat_t stat;
  logic cfg_we;
  logic [15:0] interval_size;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr == 1'b0);
  assign prdata = (paddr == 1'b0) ? {16'd0, interval_size} : 32'd0;

  bgrf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .group_end (group_end),
    .stat      (stat),
    .cmd       (cmd)
  );

  bgrf_dp #(
    .MAX_PACKETS   (MAX_PACKETS),
    .MAX_INTERVALS (MAX_INTERVALS)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .stat              (stat),
    .cfg_we            (cfg_we),
    .cfg_data          (pwdata[15:0]),
    .interval_size     (interval_size),
    .grp_id            (grp_id),
    .pkt_seq           (pkt_seq),
    .pkt_len           (pkt_len),
    .receive_time_us   (receive_time_us),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .kind              (kind),
    .ack_seq           (ack_seq),
    .first_time_us     (first_time_us),
    .last_time_us      (last_time_us),
    .fb_group_id       (fb_group_id),
    .packet_total      (packet_total),
    .low_pkt_len       (low_pkt_len),
    .grp_bytes         (grp_bytes),
    .intv_cnt          (intv_cnt),
    .interval_index    (interval_index),
    .interval_bytes    (interval_bytes),
    .last              (last)
  );

endmodule

>>> test/tb_burst_group_receive_feedback.sv
// self-checking testbench of the burst group receive feedback block
module tb_burst_group_receive_feedback;

  localparam int MAX_PKTS = 2048;
  localparam int MAX_INTV = 16;
  localparam logic [0:0] REG_INTERVAL_SIZE = 1'b0;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] ack_seq;
    logic [63:0] first_time_us;
    logic [63:0] last_time_us;
    logic [31:0] fb_group_id;
    logic [11:0] packet_total;
    logic [15:0] low_pkt_len;
    logic [20:0] grp_bytes;
    logic [4:0]  intv_cnt;
    logic [4:0]  interval_index;
    logic [15:0] interval_bytes;
    logic        last;
  } fb_result_t;

  logic clk = 0, rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [0:0] paddr = '0;
  logic [31:0] pwdata = '0, prdata;
  logic pready;
  logic in_valid = 0, in_stall;
  logic [31:0] grp_id = '0;
  logic [15:0] pkt_seq = '0, pkt_len = '0;
  logic group_end = 0;
  logic [63:0] receive_time_us = '0;
  logic out_valid, out_stall = 0;
  logic [1:0] kind;
  logic [15:0] ack_seq, low_pkt_len, interval_bytes;
  logic [63:0] first_time_us, last_time_us;
  logic [31:0] fb_group_id;
  logic [11:0] packet_total;
  logic [20:0] grp_bytes;
  logic [4:0] intv_cnt, interval_index;
  logic last;

  burst_group_receive_feedback u_top (.*);

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  // predictor copy of the group state
  logic [15:0] intv_size;
  logic [31:0] cur_group;
  int unsigned stored_pkts;
  logic [26:0] byte_total;
  logic [15:0] lo_seq, lo_size, hi_seq;
  logic [63:0] lo_time, hi_time;

  fb_result_t expected_results[$];
  int errors = 0;
  int n_items = 0, n_results = 0, n_feedbacks = 0;

  function automatic fb_result_t zero_result();
    fb_result_t r;
    r = '0;
    return r;
  endfunction

  function automatic void clear_group(logic [31:0] gid);
    cur_group = gid;
    stored_pkts = 0;
    byte_total = '0;
    lo_seq = '0; lo_size = '0; lo_time = '0;
    hi_seq = '0; hi_time = '0;
  endfunction

  function automatic void queue_feedback();
    longint unsigned cap, tot, cnt;
    fb_result_t r;
    if (stored_pkts == 0) return;
    cap = MAX_INTV * longint'(intv_size);
    tot = (byte_total < cap) ? byte_total : cap;
    cnt = (intv_size != 0) ? (tot + intv_size - 1) / intv_size : 0;
    r = zero_result();
    r.kind = bgrf_pkg::KIND_SUM;
    r.first_time_us = lo_time;
    r.last_time_us = hi_time;
    r.fb_group_id = cur_group;
    r.packet_total = stored_pkts[11:0];
    r.low_pkt_len = lo_size;
    r.grp_bytes = tot[20:0];
    r.intv_cnt = cnt[4:0];
    expected_results.push_back(r);
    n_feedbacks++;
    for (longint unsigned k = 0; k < cnt; k++) begin
      r = zero_result();
      r.kind = bgrf_pkg::KIND_INTV;
      r.fb_group_id = cur_group;
      r.interval_index = k[4:0];
      r.interval_bytes = (k + 1 == cnt) ? 16'(tot - k * intv_size) : intv_size;
      expected_results.push_back(r);
    end
  endfunction

  function automatic void predict_packet(logic [31:0] gid, logic [15:0] seq,
                                         logic [15:0] psize, logic eop,
                                         logic [63:0] t);
    fb_result_t r;
    if (cur_group == 0) clear_group(gid);
    else if (cur_group != gid) begin
      queue_feedback();
      clear_group(gid);
    end
    r = zero_result();
    r.kind = bgrf_pkg::KIND_ACK;
    r.ack_seq = seq;
    r.first_time_us = t;
    expected_results.push_back(r);
    if (stored_pkts < MAX_PKTS) begin
      if (stored_pkts == 0) begin
        lo_seq = seq; lo_time = t; lo_size = psize;
        hi_seq = seq; hi_time = t;
      end else begin
        if (seq < lo_seq) begin
          lo_seq = seq; lo_time = t; lo_size = psize;
        end
        if (seq > hi_seq) begin
          hi_seq = seq; hi_time = t;
        end
      end
      stored_pkts++;
      byte_total = byte_total + psize;
    end
    if (eop) begin
      queue_feedback();
      clear_group(0);
    end
    expected_results[$].last = 1'b1;
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // valid stays high into the next item when there is no gap
  task automatic send_packet(logic [31:0] gid, logic [15:0] seq, logic [15:0] psize,
                             logic eop, logic [63:0] t);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(negedge clk);
    end
    predict_packet(gid, seq, psize, eop, t);
    in_valid <= 1;
    grp_id <= gid;
    pkt_seq <= seq;
    pkt_len <= psize;
    group_end <= eop;
    receive_time_us <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_items++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    int guard;
    guard = 0;
    in_valid <= 0;
    while (expected_results.size() != 0 && guard < 200000) begin
      @(negedge clk);
      guard++;
    end
    // let the block sit idle between tests
    repeat (80) @(negedge clk);
  endtask

  task automatic write_interval_size(logic [15:0] v);
    @(negedge clk);
    psel <= 1; pwrite <= 1; paddr <= REG_INTERVAL_SIZE; pwdata <= {16'd0, v};
    @(negedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    intv_size = v;
  endtask

  // result checker
  always @(posedge clk) begin
    fb_result_t got, exp_r;
    if (!rst && out_valid && !out_stall) begin
      got = '{kind, ack_seq, first_time_us, last_time_us, fb_group_id, packet_total,
              low_pkt_len, grp_bytes, intv_cnt, interval_index,
              interval_bytes, last};
      n_results++;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        if (got !== exp_r) begin
          $display("%0t: mismatch expected %p", $time, exp_r);
          $display("%0t:          actual   %p", $time, got);
          errors++;
        end
      end
    end
  end

  // downstream stall
  initial begin
    int g;
    forever begin
      @(negedge clk);
      g = gap_len();
      if (g > 0) begin
        out_stall <= 1;
        repeat (g) @(negedge clk);
        out_stall <= 0;
      end
      repeat ($urandom_range(0, 4)) @(negedge clk);
    end
  end

  task automatic test_extremes();
    send_packet(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_packet(32'hFFFF_FFFF, 16'h0000, 16'h0000, 0, 64'h0);
    send_packet(32'hFFFF_FFFF, 16'h0000, 16'h1234, 0, 64'h5);  // equal seq keeps earlier
    send_packet(32'hFFFF_FFFF, 16'hFFFF, 16'h0001, 1, 64'h6);  // group end
    send_packet(32'd0, 16'd7, 16'd100, 0, 64'd10);             // group id zero opens
    send_packet(32'd5, 16'd8, 16'd100, 0, 64'd11);             // restart: no feedback
    send_packet(32'd6, 16'd9, 16'd5000, 0, 64'd12);            // change: feedback of 5
    send_packet(32'd6, 16'd3, 16'd60000, 0, 64'd13);
    send_packet(32'd6, 16'd4, 16'd65535, 1, 64'd14);           // clamped total
    send_packet(32'd9, 16'd1, 16'd4096, 1, 64'd15);            // exactly one interval
    send_packet(32'hAAAA_5555, 16'h5555, 16'hAAAA, 1, 64'hAAAA_5555_AAAA_5555);
    send_packet(32'h5555_AAAA, 16'hAAAA, 16'h5555, 1, 64'h5555_AAAA_5555_AAAA);
    wait_idle();
  endtask

  task automatic test_interval_sizes();
    logic [15:0] sizes[4] = '{16'd0, 16'd1, 16'd65535, 16'd777};
    foreach (sizes[i]) begin
      write_interval_size(sizes[i]);
      send_packet(32'd20 + i, 16'd1, 16'd40000, 0, 64'd100);
      send_packet(32'd20 + i, 16'd2, 16'd3, 1, 64'd101);
      send_packet(32'd30 + i, 16'd2, 16'd1, 1, 64'd102);
      wait_idle();
    end
  endtask

  task automatic test_random();
    logic [15:0] cfgs[3] = '{16'd4096, 16'd1000, 16'd65535};
    logic [31:0] gid;
    int left, len;
    left = 256;
    foreach (cfgs[c]) begin
      write_interval_size(cfgs[c]);
      for (int b = 0; b < 86 && left > 0; ) begin
        gid = ($urandom_range(0, 9) == 0) ? 32'd0 : $urandom_range(1, 6);
        if ($urandom_range(0, 4) == 0) gid = $urandom;
        len = $urandom_range(1, 8);
        for (int k = 0; k < len && left > 0; k++) begin
          send_packet(gid, 16'($urandom), 16'($urandom),
                      (k == len - 1) && ($urandom_range(0, 2) != 0),
                      {$urandom, $urandom});
          left--; b++;
        end
      end
      wait_idle();
    end
  endtask

  initial begin
    intv_size = 16'd4096;
    clear_group(0);
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    test_extremes();
    test_interval_sizes();
    test_random();
    wait_idle();
    $display("covered %0d packet transactions, %0d results, %0d group feedbacks",
             n_items, n_results, n_feedbacks);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d errors, %0d results missing", errors, expected_results.size());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("timeout");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

>>> filelist.f
src/bgrf_pkg.sv
src/bgrf_ctrl.sv
src/bgrf_dp.sv
src/burst_group_receive_feedback.sv
test/tb_burst_group_receive_feedback.sv
